[hdl/spq_pkg.sv]
package spq_pkg;

   // Number of entries the queue holds; the occupancy field is sized from it.
   localparam int CAPACITY = 64;
   localparam int TAG_W    = 32;
   localparam int PRIO_W   = 8;
   localparam int OCC_W    = $clog2(CAPACITY + 1);

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } spq_cmd_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_DEQUEUED = 2'd2,
      ST_EMPTY    = 2'd3
   } spq_status_type;

   typedef struct packed {
      spq_cmd_type        cmd;
      logic [TAG_W-1:0]   tag_in;
      logic [PRIO_W-1:0]  priority_in;
   } spq_req_type;

   typedef struct packed {
      spq_status_type     status;
      logic [TAG_W-1:0]   tag_out;
      logic [OCC_W-1:0]   occupancy;
   } spq_rsp_type;

   // One stored entry, as it moves between neighboring cells.
   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [TAG_W-1:0]   tag;
   } spq_entry_type;

   // Operation broadcast to every cell in the cycle an item is accepted.
   typedef struct packed {
      logic               ins;
      logic               del;
      logic [PRIO_W-1:0]  prio;
      logic [TAG_W-1:0]   tag;
   } spq_op_type;

endpackage

[hdl/spq_cell.sv]
module spq_cell import spq_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic              clock,
   input  spq_op_type        op,
   input  logic [CNT_W-1:0]  count,
   input  logic              go_prev,
   input  spq_entry_type     entry_prev,
   input  spq_entry_type     entry_next,
   output logic              go,
   output spq_entry_type     entry
);

   spq_entry_type entry_ff;
   spq_entry_type entry_in;
   logic          occupied;

   // A slot at or beyond the count is free, so a new entry always lands there
   // or earlier.
   assign occupied = count > CNT_W'(INDEX);
   assign go       = !occupied || (op.prio >= entry_ff.prio);

   always_comb begin
      entry_in = entry_ff;
      if (op.ins) begin
         if (go_prev) begin
            entry_in = entry_prev;
         end else if (go) begin
            entry_in.prio = op.prio;
            entry_in.tag  = op.tag;
         end
      end else if (op.del) begin
         entry_in = entry_next;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[hdl/sorted_priority_queue.sv]
// Channel  | Direction | Ports                            | Item
// ---------+-----------+----------------------------------+----------------------------
// request  | in        | req_valid, req_stall, req_item   | enqueue or dequeue command
// response | out       | rsp_valid, rsp_stall, rsp_item   | status, tag and occupancy
//
// Each accepted item is applied to the cell row in the cycle it is accepted,
// and its result is registered and shown in the next cycle, so one item per
// cycle is sustained while rsp_stall is low; the rate is set by the single
// response register. The request side stalls only while a result is held and
// the response side stalls. Reset (synchronous, active high) empties the queue
// and the response register; the cell contents themselves are not cleared.
module sorted_priority_queue import spq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  spq_req_type  req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output spq_rsp_type  rsp_item
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   spq_rsp_type      rsp_item_ff;
   spq_rsp_type      rsp_item_in;

   logic             accept;
   logic             full;
   logic             empty;
   spq_op_type       op;

   // Cell row wiring: each cell sees the decision and entry of its neighbors.
   logic             go_vec [CAPACITY];
   spq_entry_type    entry_vec [CAPACITY];

   // A new item is taken whenever the response register is free or is being
   // emptied in this same cycle.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full  = count_ff == CNT_W'(CAPACITY);
   assign empty = count_ff == '0;

   // Inserts into a full queue and removals from an empty one leave the row
   // untouched; they only produce a flagged result.
   always_comb begin
      op.ins  = accept && (req_item.cmd == CMD_ENQUEUE) && !full;
      op.del  = accept && (req_item.cmd == CMD_DEQUEUE) && !empty;
      op.prio = req_item.priority_in;
      op.tag  = req_item.tag_in;
   end

   // The row stays sorted by descending priority with the front at cell 0.
   // On an insert every cell compares the new priority with its own entry;
   // the first cell that finds the new priority not smaller takes the new
   // entry and every cell behind it takes its front neighbor's entry. Equal
   // priorities therefore put the newest entry ahead. On a removal every cell
   // takes its back neighbor's entry.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic          go_prev;
      spq_entry_type entry_prev;
      spq_entry_type entry_next;

      if (i == 0) begin : g_first
         assign go_prev    = 1'b0;
         assign entry_prev = entry_vec[i];
      end else begin : g_mid
         assign go_prev    = go_vec[i-1];
         assign entry_prev = entry_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign entry_next = entry_vec[i];
      end else begin : g_body
         assign entry_next = entry_vec[i+1];
      end

      spq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .count      (count_ff),
         .go_prev    (go_prev),
         .entry_prev (entry_prev),
         .entry_next (entry_next),
         .go         (go_vec[i]),
         .entry      (entry_vec[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (op.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (op.del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Result of the accepted item: status code, the front tag on a removal,
   // and the occupancy after the item.
   always_comb begin
      rsp_item_in.tag_out   = '0;
      rsp_item_in.occupancy = OCC_W'(count_in);
      case (req_item.cmd)
         CMD_ENQUEUE: begin
            rsp_item_in.status = full ? ST_FULL : ST_INSERTED;
         end
         CMD_DEQUEUE: begin
            if (empty) begin
               rsp_item_in.status = ST_EMPTY;
            end else begin
               rsp_item_in.status  = ST_DEQUEUED;
               rsp_item_in.tag_out = entry_vec[0].tag;
            end
         end
         default: begin
            rsp_item_in.status = ST_EMPTY;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[dv/sorted_priority_queue_tb.sv]
module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH = CAPACITY;
   // Roughly how many items the whole run sends, directed part included.
   localparam int ITEM_TARGET = 500;
   // The slowest correct run is about 600 items, each with the longest idle on
   // the sender and the longest stall on the receiver before its transfer. The
   // limit is many times that.
   localparam int CYCLE_LIMIT = 400000;

   // Shadow copy of the queue. It keeps its own sorted array, works out the
   // result of every accepted item, and checks results in arrival order.
   class queue_shadow;
      logic [PRIO_W-1:0] held_prio [QUEUE_DEPTH];
      logic [TAG_W-1:0]  held_tag  [QUEUE_DEPTH];
      int unsigned       held_count;
      spq_rsp_type       due_results [$];
      int                mismatches;
      int                status_seen [4];
      int unsigned       peak_count;

      function spq_rsp_type predict_outcome(spq_req_type r);
         spq_rsp_type res;
         int          pos;
         res = '0;
         if (r.cmd == CMD_ENQUEUE) begin
            if (held_count >= QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // Stop at the first entry that is not strictly higher, so a
               // newcomer goes ahead of entries with the same priority.
               pos = 0;
               while (pos < held_count && r.priority_in < held_prio[pos]) pos++;
               for (int k = held_count; k > pos; k--) begin
                  held_prio[k] = held_prio[k-1];
                  held_tag[k]  = held_tag[k-1];
               end
               held_prio[pos] = r.priority_in;
               held_tag[pos]  = r.tag_in;
               held_count++;
               res.status = ST_INSERTED;
            end
         end else if (held_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.status  = ST_DEQUEUED;
            res.tag_out = held_tag[0];
            for (int k = 0; k + 1 < held_count; k++) begin
               held_prio[k] = held_prio[k+1];
               held_tag[k]  = held_tag[k+1];
            end
            held_count--;
         end
         res.occupancy = OCC_W'(held_count);
         if (held_count > peak_count) peak_count = held_count;
         return res;
      endfunction

      function void note_request(spq_req_type r);
         due_results.push_back(predict_outcome(r));
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("tb: mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_result(spq_rsp_type got);
         spq_rsp_type want;
         if (due_results.size() == 0) begin
            report_mismatch("result with nothing outstanding, status", got.status, 0);
         end else begin
            want = due_results.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.tag_out !== want.tag_out)
               report_mismatch("tag_out", got.tag_out, want.tag_out);
            if (got.occupancy !== want.occupancy)
               report_mismatch("occupancy", got.occupancy, want.occupancy);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   spq_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   spq_rsp_type rsp_item;

   queue_shadow shadow = new();
   int          sent_total = 0;
   int          cycle_count = 0;
   // When set, both sides stop idling so the block runs at full rate.
   bit          no_idle = 1'b0;

   sorted_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog. Any hang, lost result or stuck handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Both channels are observed at the clock edge. An item moves whenever
   // valid is high and stall is low. The request is noted before the result
   // is checked; a result never belongs to the item accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) shadow.note_request(req_item);
         if (rsp_valid && !rsp_stall) shadow.check_result(rsp_item);
      end
   end

   // Idle time before each item on either side. At least half the draws are zero so
   // the queue fills up; the rest spread over the whole range.
   function int draw_wait();
      if (no_idle || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   // Sends one item. A gap lowers valid for a while; with no gap valid stays
   // high across items so back-to-back transfers happen. The task returns at
   // the edge where the item was taken.
   task push_cmd(spq_cmd_type cmd, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio);
      spq_req_type r;
      int          gap;
      r.cmd         = cmd;
      r.tag_in      = tag;
      r.priority_in = prio;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_total++;
   endtask

   // The first edge lets the monitor note the item taken at the edge where
   // the caller returned before the outstanding results are counted.
   task wait_drained();
      @(posedge clock);
      while (shadow.due_results.size() != 0) @(posedge clock);
   endtask

   // Receiver. Before each result it holds stall high for a drawn number of
   // cycles, then takes one result and draws again. The stall window runs
   // whether or not a result is waiting, so it lands on every phase.
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = draw_wait();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   initial begin
      int enq_pct;
      int prio_mode;
      int round_len;
      logic [PRIO_W-1:0] prio;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part. It starts on an empty queue, stacks the extreme
      // priorities and a run of equal ones, then drains past empty. The
      // dequeue order shows that equal priorities come out newest first.
      push_cmd(CMD_DEQUEUE, 32'hFFFF_FFFF, 8'hFF);
      push_cmd(CMD_ENQUEUE, 32'hFFFF_FFFF, 8'hFF);
      push_cmd(CMD_ENQUEUE, 32'h0000_0000, 8'h00);
      push_cmd(CMD_ENQUEUE, 32'h0000_0001, 8'h80);
      push_cmd(CMD_ENQUEUE, 32'h0000_0002, 8'h80);
      push_cmd(CMD_ENQUEUE, 32'h0000_0003, 8'h80);
      push_cmd(CMD_ENQUEUE, 32'hAAAA_AAAA, 8'hFF);
      push_cmd(CMD_ENQUEUE, 32'h5555_5555, 8'h00);
      repeat (7) push_cmd(CMD_DEQUEUE, 32'h0, 8'h0);
      push_cmd(CMD_DEQUEUE, 32'h1234_5678, 8'h5A);
      push_cmd(CMD_ENQUEUE, 32'h8000_0000, 8'h01);
      push_cmd(CMD_ENQUEUE, 32'h7FFF_FFFF, 8'hFE);
      repeat (3) push_cmd(CMD_DEQUEUE, 32'h0, 8'h0);

      // The sender holds off until every outstanding result has come back.
      req_valid <= 1'b0;
      wait_drained();

      // Fill past capacity so the last enqueues are dropped, then empty the
      // queue and keep asking so the empty case repeats.
      repeat (QUEUE_DEPTH + 6) push_cmd(CMD_ENQUEUE, $urandom, 8'($urandom));
      repeat (QUEUE_DEPTH + 6) push_cmd(CMD_DEQUEUE, $urandom, 8'($urandom));

      // Random rounds. Each round picks a mix of enqueues and dequeues and a
      // priority spread: the full range, a handful of values so ties are
      // common, or only the two extremes. Some rounds run with no idling.
      while (sent_total < ITEM_TARGET) begin
         case ($urandom_range(0, 3))
            0: enq_pct = 25;
            1: enq_pct = 50;
            2: enq_pct = 70;
            default: enq_pct = 90;
         endcase
         prio_mode = $urandom_range(0, 2);
         no_idle   = ($urandom_range(0, 4) == 0);
         round_len = $urandom_range(20, 60);
         repeat (round_len) begin
            case (prio_mode)
               0: prio = 8'($urandom);
               1: prio = 8'($urandom_range(0, 3));
               default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            push_cmd(($urandom_range(1, 100) <= enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE,
                     $urandom, prio);
         end
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      // Let the last results come back, then keep watching in case the block
      // produces anything unexpected.
      wait_drained();
      repeat (8) @(posedge clock);
      if (shadow.due_results.size() != 0)
         shadow.report_mismatch("results still outstanding", shadow.due_results.size(), 0);

      $display("tb: %0d items sent: %0d inserted, %0d dropped when full, %0d dequeued, %0d empty",
               sent_total, shadow.status_seen[ST_INSERTED], shadow.status_seen[ST_FULL],
               shadow.status_seen[ST_DEQUEUED], shadow.status_seen[ST_EMPTY]);
      $display("tb: peak occupancy %0d of %0d, %0d mismatches, %0d cycles",
               shadow.peak_count, QUEUE_DEPTH, shadow.mismatches, cycle_count);
      if (shadow.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
